@@ sv/wht_pkg.sv @@
// Package: shared types, constants and helper functions for the Walsh-Hadamard transform unit.
`default_nettype none
package wht_pkg;
  localparam int MaxPoints = 64;
  localparam int AddrW     = 6;
  localparam int DataW     = 23;
  localparam int QDepth    = 2;
  localparam logic [2:0] MaxLog2 = 3'd6;
  localparam logic [30:0] Sqrt2Q30 = 31'd1518500250;

  localparam logic [0:0] RegPointsLog2 = 1'b0;
  localparam logic [0:0] RegOrderMode  = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               req_type;
  } wht_in_t;

  typedef struct packed {
    logic signed [23:0] coefficient;
    logic [5:0]         index;
    logic               last_out;
  } wht_out_t;

  // Job handed from the front part to the back part.
  typedef struct packed {
    logic [2:0] lg;
    logic [6:0] used;
    logic       perm_in;
    logic       perm_out;
  } wht_job_t;

  typedef enum logic [2:0] {
    B_IDLE, B_COPY, B_BFLY_RD, B_BFLY_WR, B_EMIT
  } wht_bstate_t;

  // Gray code of k, followed by the bit reverse of its low lg bits.
  function automatic logic [5:0] seq_pos(input logic [5:0] k, input logic [2:0] lg);
    logic [5:0] g;
    logic [5:0] r;
    g = k ^ (k >> 1);
    r = '0;
    for (int b = 0; b < 6; b++) begin
      if (b < lg) r[lg - 3'd1 - 3'(b)] = g[b];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

@@ sv/wht_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wht_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/wht_front.sv @@
// Front part: loads samples into the sample buffer and queues a job on the last request.
`default_nettype none
module wht_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire wht_pkg::wht_in_t req,
  input  wire logic [2:0]     points_log2,
  input  wire logic           order_mode,
  output logic                buf_we,
  output logic [5:0]          buf_waddr,
  output logic [15:0]         buf_wdata,
  output logic                job_push,
  output wht_pkg::wht_job_t   job
);
  import wht_pkg::*;

  logic [6:0] fill_count;
  logic [2:0] lg;
  logic [6:0] n;
  logic       store;

  // Clamp the length and decide whether this sample is kept.
  always_comb begin
    lg = (points_log2 > MaxLog2) ? MaxLog2 : points_log2;
    n = 7'd1 << lg;
    store = accept && (fill_count < n);
    buf_we = store;
    buf_waddr = fill_count[5:0];
    buf_wdata = req.sample;
    job_push = accept && req.last;
    job.lg = lg;
    job.used = store ? fill_count + 7'd1 : ((fill_count < n) ? fill_count : n);
    job.perm_in = order_mode && req.req_type;
    job.perm_out = order_mode && !req.req_type;
  end

  // Fill count restarts after every block.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (job_push) begin
      fill_count <= '0;
    end else if (store) begin
      fill_count <= fill_count + 7'd1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill_count <= 7'd64)
    else $error("fill count beyond buffer");
  assert property (@(posedge clk) disable iff (rst) job_push |=> fill_count == 7'd0)
    else $error("fill count not cleared after a block");
  assert property (@(posedge clk) disable iff (rst) job_push |-> job.used <= n)
    else $error("job uses more samples than the length");
endmodule
`default_nettype wire

@@ sv/wht_back.sv @@
// Back part: copies samples into the work buffer, runs the butterflies, scales and emits.
`default_nettype none
module wht_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_valid,
  input  wire wht_pkg::wht_job_t job_in,
  output logic                   job_pop,
  output logic                   copy_busy,
  output logic [5:0]             sbuf_raddr,
  input  wire logic [15:0]       sbuf_rdata,
  output logic                   done,
  output wht_pkg::wht_out_t      result
);
  import wht_pkg::*;

  wht_bstate_t state, state_next;
  wht_job_t    job;
  logic [6:0]  cnt, cnt_next;
  logic [2:0]  stage, stage_next;
  logic        rd_ok;
  logic [6:0]  n;

  // Work buffer: two copies written together give the two read ports that one
  // butterfly needs, so both legs of a pair are read in the same cycle.
  logic            wa_we, wb_we;
  logic [5:0]      wa_addr_w, wa_raddr, wb_raddr;
  logic [DataW-1:0] wa_wdata, wa_rdata, wb_rdata;
  logic [DataW-1:0] hold_a;
  logic [5:0]      pb_hold;
  logic [5:0]      pa, pb;

  wht_ram #(.Width(DataW), .Depth(MaxPoints)) u_wa (
    .clk, .we(wa_we), .waddr(wa_addr_w), .wdata(wa_wdata), .raddr(wa_raddr), .rdata(wa_rdata));
  wht_ram #(.Width(DataW), .Depth(MaxPoints)) u_wb (
    .clk, .we(wb_we), .waddr(wa_addr_w), .wdata(wa_wdata), .raddr(wb_raddr), .rdata(wb_rdata));

  // Butterfly pair addresses from the pair counter and stage.
  logic [5:0] j6, hmask, lowpart, highpart;
  always_comb begin
    n = 7'd1 << job.lg;
    j6 = cnt[5:0];
    hmask = 6'((7'd1 << stage) - 7'd1);
    lowpart = j6 & hmask;
    highpart = (j6 & ~hmask) << 1;
    pa = highpart | lowpart;
    pb = pa | 6'(7'd1 << stage);
  end

  // Scaling pipeline: registered read, multiply, round.
  logic              emit_v1, emit_v2, emit_v3;
  logic [5:0]        idx1, idx2, idx3;
  logic signed [DataW-1:0] v2;
  logic signed [55:0] prod3;
  logic [5:0]        emit_src;

  always_comb begin
    emit_src = job.perm_out ? seq_pos(cnt[5:0], job.lg) : cnt[5:0];
  end

  assign copy_busy = (state == B_COPY);

  // Next state and memory controls.
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    stage_next = stage;
    job_pop = 1'b0;
    sbuf_raddr = cnt[5:0];
    wa_we = 1'b0;
    wb_we = 1'b0;
    wa_addr_w = '0;
    wa_wdata = '0;
    wa_raddr = pa;
    wb_raddr = pb;
    unique case (state)
      B_IDLE: begin
        // The emit pipeline still uses the current job's length until it empties.
        if (job_valid && !emit_v1 && !emit_v2 && !emit_v3) begin
          job_pop = 1'b1;
          cnt_next = '0;
          state_next = B_COPY;
        end
      end
      B_COPY: begin
        // Cycle cnt reads sample cnt; next cycle writes it at (permuted) cnt-1.
        if (cnt != 7'd0) begin
          wa_we = 1'b1;
          wb_we = 1'b1;
          wa_addr_w = job.perm_in ? seq_pos(6'(cnt - 7'd1), job.lg) : 6'(cnt - 7'd1);
          wa_wdata = ((cnt - 7'd1) < job.used) ? DataW'($signed(sbuf_rdata)) : '0;
        end
        if (cnt == n) begin
          cnt_next = '0;
          stage_next = '0;
          state_next = (job.lg == 3'd0) ? B_EMIT : B_BFLY_RD;
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      B_BFLY_RD: begin
        state_next = B_BFLY_WR;
      end
      B_BFLY_WR: begin
        // Two writes per pair: sum now, difference next cycle via hold.
        wa_we = 1'b1;
        wb_we = 1'b1;
        wa_addr_w = pa;
        wa_wdata = wa_rdata + wb_rdata;
        state_next = B_BFLY_RD;
        if (cnt == (n >> 1) - 7'd1) begin
          cnt_next = '0;
          if (stage == job.lg - 3'd1) state_next = B_EMIT;
          else stage_next = stage + 3'd1;
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      B_EMIT: begin
        wa_raddr = emit_src;
        if (cnt == n - 7'd1) begin
          cnt_next = '0;
          state_next = B_IDLE;
        end else begin
          cnt_next = cnt + 7'd1;
        end
      end
      default: state_next = B_IDLE;
    endcase
    // Pending difference write from the previous butterfly.
    if (rd_ok) begin
      wa_we = 1'b1;
      wb_we = 1'b1;
      wa_addr_w = pb_hold;
      wa_wdata = hold_a;
    end
  end

  // Difference is written in the read cycle of the next pair (or the emit turn).
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      rd_ok <= 1'b0;
      cnt <= '0;
      stage <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      stage <= stage_next;
      rd_ok <= (state == B_BFLY_WR);
    end
    if (job_pop) job <= job_in;
    if (state == B_BFLY_WR) begin
      hold_a <= wa_rdata - wb_rdata;
      pb_hold <= pb;
    end
  end

  // Round to nearest, ties away from zero: |prod*16| >> (30 + shift).
  logic [5:0] sh;
  logic [59:0] mag, rmag;
  logic signed [23:0] rounded;
  always_comb begin
    sh = 6'd26 + 6'((job.lg + 3'd1) >> 1);
    mag = prod3[55] ? 60'(-prod3) : 60'(prod3);
    rmag = (mag + (60'd1 << (sh - 6'd1))) >> sh;
    rounded = prod3[55] ? -24'(rmag) : 24'(rmag);
  end

  // Emit pipeline: RAM read, multiply, round and present.
  logic odd;
  assign odd = job.lg[0];
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_v1 <= 1'b0;
      emit_v2 <= 1'b0;
      emit_v3 <= 1'b0;
      done <= 1'b0;
    end else begin
      emit_v1 <= (state == B_EMIT);
      emit_v2 <= emit_v1;
      emit_v3 <= emit_v2;
      done <= emit_v3;
    end
    idx1 <= cnt[5:0];
    idx2 <= idx1;
    idx3 <= idx2;
    v2 <= wa_rdata;
    prod3 <= odd ? $signed(v2) * $signed({1'b0, Sqrt2Q30}) : 56'($signed(v2)) <<< 30;
    result.index <= idx3;
    result.last_out <= ({1'b0, idx3} == n - 7'd1);
    result.coefficient <= rounded;
  end

  assert property (@(posedge clk) disable iff (rst) job_pop |-> job_valid)
    else $error("job popped from an empty queue");
  assert property (@(posedge clk) disable iff (rst) done && result.last_out |=> !done)
    else $error("result after the final result of a block");
  assert property (@(posedge clk) disable iff (rst) state == B_BFLY_WR |=> rd_ok)
    else $error("difference write lost");
endmodule
`default_nettype wire

@@ sv/walsh_hadamard_transform_unit.sv @@
// Top level of the Walsh-Hadamard transform unit.
// Usage: samples arrive as requests on start/request while busy is low; the
// request with last set closes a block and selects forward or inverse.
// Configuration (points_log2, order_mode) is written through cfg_we,
// cfg_index and cfg_data while the unit is idle; writes take effect at once.
// A request is accepted at a rising edge with start high and busy low.
// Each accepted request loads its sample, up to N. After the last request the
// back part copies N samples, runs N/2*log2(N) butterflies, each in a read
// state and a write state, then emits N results on done/result, one per
// cycle, through a pipeline of buffer read, multiply and rounding. The next
// block loads while the back part works, but busy is high from the closing
// request until the back part has copied that block out of the sample buffer,
// so only one block waits at a time. The back part takes a new block only
// once its emit pipeline is empty, so it does not start a block before the
// last one is out. The receiver cannot stall: every result is valid for
// exactly one cycle. Reset clears the fill count, the queue and the back
// part's state and restores points_log2 = 6 and order_mode = 0.
`default_nettype none
module walsh_hadamard_transform_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire wht_pkg::wht_in_t request,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [2:0]       cfg_data,
  output logic                  done,
  output wht_pkg::wht_out_t     result
);
  import wht_pkg::*;

  logic [2:0] points_log2;
  logic       order_mode;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      points_log2 <= 3'd6;
      order_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegPointsLog2: points_log2 <= cfg_data;
        RegOrderMode:  order_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic accept, buf_we, job_push, job_pop, copy_busy;
  logic [5:0] buf_waddr, sbuf_raddr;
  logic [15:0] buf_wdata, sbuf_rdata;
  wht_job_t job_f, job_b;

  // A full queue or a pending copy blocks new samples: a block may not overwrite
  // the buffer still being copied, as one sample buffer serves every queue slot.
  logic [1:0] q_cnt;
  logic q_wp, q_rp;
  wht_job_t q [QDepth];
  logic copying;

  assign busy = (q_cnt == 2'(QDepth)) || copying;
  assign accept = start && !busy;

  wht_front u_front (
    .clk, .rst, .accept, .req(request), .points_log2, .order_mode,
    .buf_we, .buf_waddr, .buf_wdata, .job_push, .job(job_f));

  wht_ram #(.Width(16), .Depth(MaxPoints)) u_sbuf (
    .clk, .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
    .raddr(sbuf_raddr), .rdata(sbuf_rdata));

  // Job queue between front and back.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
      q_wp <= 1'b0;
      q_rp <= 1'b0;
    end else begin
      if (job_push) q_wp <= ~q_wp;
      if (job_pop) q_rp <= ~q_rp;
      q_cnt <= q_cnt + 2'(job_push) - 2'(job_pop);
    end
    if (job_push) q[q_wp] <= job_f;
  end
  assign job_b = q[q_rp];

  // Hold off new samples while a queued block still lives in the sample buffer.
  always_ff @(posedge clk) begin
    if (rst) copying <= 1'b0;
    else if (job_push) copying <= 1'b1;
    else if (q_cnt == 2'd0 && !copy_busy) copying <= 1'b0;
  end

  wht_back u_back (
    .clk, .rst, .job_valid(q_cnt != 2'd0), .job_in(job_b), .job_pop, .copy_busy,
    .sbuf_raddr, .sbuf_rdata, .done, .result);

  assert property (@(posedge clk) disable iff (rst) accept |-> !busy)
    else $error("request taken while busy");
  assert property (@(posedge clk) disable iff (rst) q_cnt <= 2'(QDepth))
    else $error("job queue overflow");
  assert property (@(posedge clk) disable iff (rst) !(job_pop && q_cnt == 2'd0))
    else $error("job queue underflow");
endmodule
`default_nettype wire

@@ bench/wht_scoreboard.sv @@
// Checker that predicts the Walsh-Hadamard unit's results and compares them.
module wht_scoreboard (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire wht_pkg::wht_in_t request,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [2:0]       cfg_data,
  input  wire logic             done,
  input  wire wht_pkg::wht_out_t result,
  output int                    fail_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import wht_pkg::*;

  localparam longint Sqrt2 = 64'd1518500250;

  logic signed [15:0] sample_store [MaxPoints];
  int unsigned        fill;
  logic [2:0]         lg_reg;
  logic               seq_mode;
  wht_out_t           coeff_queue [$];

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  // Bit reverse of the Gray code of k over lg bits.
  function automatic int unsigned gray_rev(input int unsigned k, input int unsigned lg);
    int unsigned g;
    int unsigned r;
    g = k ^ (k >> 1);
    r = 0;
    for (int b = 0; b < lg; b++) if (g[b]) r |= 1 << (lg - 1 - b);
    return r;
  endfunction

  // Round to nearest with ties away from zero, then shift right.
  function automatic longint round_shift(input longint v, input int unsigned sh);
    longint m;
    m = (v < 0) ? -v : v;
    if (sh > 0) m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic int unsigned eff_lg();
    return (lg_reg > MaxLog2) ? int'(MaxLog2) : int'(lg_reg);
  endfunction

  // Transform the stored block and queue its N coefficients.
  task automatic predict_block(input logic inverse);
    longint      d [MaxPoints];
    int unsigned lg;
    int unsigned n;
    int unsigned used;
    int unsigned pos;
    int unsigned h;
    longint      a;
    longint      b;
    longint      v;
    wht_out_t    o;
    lg = eff_lg();
    n = 1 << lg;
    used = (fill < n) ? fill : n;
    for (int i = 0; i < MaxPoints; i++) d[i] = 0;
    for (int i = 0; i < used; i++) begin
      pos = (seq_mode && inverse) ? gray_rev(i, lg) : i;
      d[pos] = sample_store[i];
    end
    for (int len = 2; len <= n; len = len * 2) begin
      h = len / 2;
      for (int i = 0; i < n; i += len) begin
        for (int j = 0; j < h; j++) begin
          a = d[i + j];
          b = d[i + j + h];
          d[i + j] = a + b;
          d[i + j + h] = a - b;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      pos = (seq_mode && !inverse) ? gray_rev(k, lg) : k;
      v = d[pos];
      if (lg[0] == 1'b0) v = round_shift(v * 16, lg >> 1);
      else v = round_shift(v * 16 * Sqrt2, 30 + ((lg + 1) >> 1));
      o.coefficient = v[23:0];
      o.index = k[5:0];
      o.last_out = (k == n - 1);
      coeff_queue.push_back(o);
    end
    fill = 0;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // All signals are sampled at the falling edge, before the rising edge that takes them.
  always @(negedge clk) begin
    if (rst) begin
      fill = 0;
      lg_reg = 3'd6;
      seq_mode = 1'b0;
      coeff_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == RegPointsLog2) lg_reg = cfg_data;
        else seq_mode = cfg_data[0];
      end
      if (done) begin
        if (coeff_queue.size() == 0) begin
          report_mismatch("unexpected result index", result.index, -1);
        end else begin
          if (result.coefficient !== coeff_queue[0].coefficient)
            report_mismatch("coefficient", result.coefficient, coeff_queue[0].coefficient);
          if (result.index !== coeff_queue[0].index)
            report_mismatch("index", result.index, coeff_queue[0].index);
          if (result.last_out !== coeff_queue[0].last_out)
            report_mismatch("last_out", result.last_out, coeff_queue[0].last_out);
          void'(coeff_queue.pop_front());
        end
      end
      if (start && !busy) begin
        if (fill < (1 << eff_lg())) begin
          sample_store[fill] = request.sample;
          fill++;
        end
        if (request.last) predict_block(request.req_type);
      end
    end
    pending_count = coeff_queue.size();
  end
endmodule

@@ bench/walsh_hadamard_transform_unit_tb.sv @@
// Testbench top: drives requests and configuration and gives the verdict.
module walsh_hadamard_transform_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wht_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  wht_in_t  request;
  logic     cfg_we;
  logic     cfg_index;
  logic [2:0] cfg_data;
  logic     done;
  wht_out_t result;
  int       fail_count;
  int       pending_count;
  int       idle_pct;
  int       quiet_cycles;

  walsh_hadamard_transform_unit u_top (
    .clk, .rst, .start, .busy, .request, .cfg_we, .cfg_index, .cfg_data, .done, .result
  );

  wht_scoreboard u_scoreboard (
    .clk, .rst, .start, .busy, .request, .cfg_we, .cfg_index, .cfg_data, .done, .result,
    .fail_count, .pending_count
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: counts cycles in which no request and no result is taken.
  initial quiet_cycles = 0;
  always @(negedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("walsh_hadamard_transform_unit regression: fail");
      $finish;
    end
  end

  // Send one request, idling first at the current rate. Start stays high after
  // the accepting edge; the next call or drain() sets it for the next cycle.
  task automatic send_sample(input logic signed [15:0] s, input logic lst, input logic inv);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    request <= '{sample: s, last: lst, req_type: inv};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
  endtask

  // Wait until every coefficient has come out, then let the pipeline drain.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [2:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [2:0] lg, input logic seq);
    drain();
    write_reg(RegPointsLog2, lg);
    write_reg(RegOrderMode, {2'b00, seq});
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // Send a block of cnt samples, the last one closing it.
  task automatic send_block(input int cnt, input logic inv);
    for (int i = 0; i < cnt; i++) send_sample(rand_sample(), i == cnt - 1, inv);
  endtask

  initial begin
    int items;
    int lg;
    int n;
    int cnt;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_we = 1'b0;
    cfg_index = RegPointsLog2;
    cfg_data = '0;
    idle_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single point, extremes of the sample range.
    configure(3'd0, 1'b0);
    send_sample(16'sh8000, 1'b1, 1'b0);
    send_sample(16'sh7fff, 1'b1, 1'b1);
    // Overflowing block of four samples into two points, inverse, natural order.
    configure(3'd1, 1'b0);
    send_sample(16'sh7fff, 1'b0, 1'b0);
    send_sample(16'sh7fff, 1'b0, 1'b0);
    send_sample(16'sh8000, 1'b0, 1'b0);
    send_sample(16'sh8000, 1'b1, 1'b1);
    // Sequency order at eight points, forward then inverse, with a short block.
    configure(3'd3, 1'b1);
    for (int i = 0; i < 8; i++) send_sample(16'(i * 1000 - 32768), i == 7, 1'b0);
    send_sample(16'sh7fff, 1'b0, 1'b1);
    send_sample(16'sh8000, 1'b1, 1'b1);
    // Oversized length saturates to 64 points; a single sample at the maximum.
    configure(3'd7, 1'b1);
    send_sample(16'sh7fff, 1'b1, 1'b0);
    // Length changed in the middle of a block.
    configure(3'd2, 1'b0);
    send_sample(16'sh1234, 1'b0, 1'b0);
    send_sample(-16'sh0042, 1'b0, 1'b0);
    send_sample(16'sh0005, 1'b0, 1'b0);
    drain();
    write_reg(RegPointsLog2, 3'd1);
    send_sample(16'sh7fff, 1'b1, 1'b1);

    // Random blocks in three phases of sender idling.
    items = 0;
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 8 : (phase == 1) ? 59 : 0;
      while (items < (phase + 1) * 45) begin
        lg = ($urandom_range(9) == 0) ? 6 + $urandom_range(1) : $urandom_range(4);
        configure(3'(lg), 1'($urandom));
        for (int b = 0; b < 3 && items < (phase + 1) * 45; b++) begin
          n = 1 << ((lg > 6) ? 6 : lg);
          case ($urandom_range(5))
            0: cnt = 1 + $urandom_range(n - 1);
            1: cnt = n + 1 + $urandom_range(2);
            default: cnt = n;
          endcase
          send_block(cnt, 1'($urandom));
          items += cnt;
        end
      end
    end

    drain();
    if (fail_count == 0 && pending_count == 0) begin
      $display("walsh_hadamard_transform_unit regression: pass");
    end else begin
      $display("walsh_hadamard_transform_unit regression: fail");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
sv/wht_pkg.sv
sv/wht_ram.sv
sv/wht_front.sv
sv/wht_back.sv
sv/walsh_hadamard_transform_unit.sv
bench/wht_scoreboard.sv
bench/walsh_hadamard_transform_unit_tb.sv
